// ===== rtl/core/cdq_pkg.sv =====
package cdq_pkg;

  // build defaults
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // request codes
  typedef enum logic [1:0] {
    REQ_PUSH_HEAD = 2'd0,
    REQ_PUSH_TAIL = 2'd1,
    REQ_POP_HEAD  = 2'd2,
    REQ_POP_TAIL  = 2'd3
  } cdq_req_t;

  // status codes
  localparam logic [1:0] ST_DONE       = 2'd0;
  localparam logic [1:0] ST_PUSH_FULL  = 2'd1;
  localparam logic [1:0] ST_POP_EMPTY  = 2'd2;

  // input item
  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] data_value;
  } cdq_in_t;

  // result item
  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  element_count;
    logic        is_empty;
    logic [31:0] head_value;
    logic [31:0] tail_value;
  } cdq_out_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic push_head;
    logic push_tail;
    logic pop_head;
    logic pop_tail;
  } cdq_op_t;

endpackage

// ===== rtl/core/cdq_cell.sv =====
// One slot of the deque row. Slots are packed from cell 0 (head) toward the
// end; occupancy is a thermometer code carried one bit per cell.
module cdq_cell #(
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cdq_pkg::cdq_op_t      op,
  input  logic [DATA_WIDTH-1:0] push_val,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic                  left_occ,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic                  right_occ,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  occ,
  output logic                  is_tail
);

  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic                  occ_r, occ_nxt;

  // next slot contents
  always_comb begin
    data_nxt = data_r;
    occ_nxt  = occ_r;
    if (op.push_head) begin
      data_nxt = left_data;
      occ_nxt  = left_occ;
    end else if (op.push_tail) begin
      // first free slot takes the new value
      if (!occ_r && left_occ) begin
        data_nxt = push_val;
      end
      occ_nxt = occ_r | left_occ;
    end else if (op.pop_head) begin
      data_nxt = right_data;
      occ_nxt  = right_occ;
    end else if (op.pop_tail) begin
      occ_nxt = occ_r & right_occ;
    end
  end

  // occupancy is control state, data is payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign occ     = occ_r;
  assign is_tail = occ_r & ~right_occ;

endmodule

// ===== rtl/core/circular_deque_top.sv =====
// Channel   | Ports                          | Direction | Payload
// ----------+--------------------------------+-----------+------------------
// request   | in_valid, in_ready, in_data    | in        | cdq_pkg::cdq_in_t
// result    | out_valid, out_ready, out_data | out       | cdq_pkg::cdq_out_t
//
// For each item the row of cells is first shifted or written; head and tail are
// then read from the row into the result register.
// A new item is taken while the previous result still waits at the output.
// An output stall holds the row update's result step until out_ready allows it.
// Reset (rst_n low, synchronous) empties the deque; no clearing pass is needed.
module circular_deque_top #(
  parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cdq_pkg::cdq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cdq_pkg::cdq_out_t out_data
);

  localparam int CW = $clog2(DEPTH + 1);

  logic                  busy_r, busy_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [1:0]            status_r, status_nxt;
  cdq_pkg::cdq_out_t     out_data_r;
  cdq_pkg::cdq_op_t      op;
  cdq_pkg::cdq_req_t     req;
  logic                  accept, load;
  logic                  is_full, is_emp;
  logic [DATA_WIDTH-1:0] push_val;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]      cell_occ;
  logic [DEPTH-1:0]      cell_tail;
  logic [DATA_WIDTH-1:0] tail_sel;

  assign in_ready = ~busy_r;
  assign accept   = in_valid & in_ready;
  assign load     = busy_r & (~out_valid_r | out_ready);
  assign req      = cdq_pkg::cdq_req_t'(in_data.req_type);
  assign push_val = DATA_WIDTH'(in_data.data_value);
  assign is_full  = (count_r == CW'(DEPTH));
  assign is_emp   = (count_r == '0);

  // request decode and count update
  always_comb begin
    op         = '0;
    count_nxt  = count_r;
    status_nxt = status_r;
    if (accept) begin
      status_nxt = cdq_pkg::ST_DONE;
      unique case (req) inside
        cdq_pkg::REQ_PUSH_HEAD, cdq_pkg::REQ_PUSH_TAIL: begin
          if (is_full) begin
            status_nxt = cdq_pkg::ST_PUSH_FULL;
          end else begin
            op.push_head = (req == cdq_pkg::REQ_PUSH_HEAD);
            op.push_tail = (req == cdq_pkg::REQ_PUSH_TAIL);
            count_nxt    = count_r + CW'(1);
          end
        end
        cdq_pkg::REQ_POP_HEAD, cdq_pkg::REQ_POP_TAIL: begin
          if (is_emp) begin
            status_nxt = cdq_pkg::ST_POP_EMPTY;
          end else begin
            op.pop_head = (req == cdq_pkg::REQ_POP_HEAD);
            op.pop_tail = (req == cdq_pkg::REQ_POP_TAIL);
            count_nxt   = count_r - CW'(1);
          end
        end
        default: begin
          status_nxt = cdq_pkg::ST_DONE;
        end
      endcase
    end
  end

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] l_data, r_data;
    logic                  l_occ, r_occ;
    if (i == 0) begin : g_first
      assign l_data = push_val;
      assign l_occ  = 1'b1;
    end else begin : g_mid_l
      assign l_data = cell_data[i-1];
      assign l_occ  = cell_occ[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign r_data = cell_data[i];
      assign r_occ  = 1'b0;
    end else begin : g_mid_r
      assign r_data = cell_data[i+1];
      assign r_occ  = cell_occ[i+1];
    end
    cdq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .op        (op),
      .push_val  (push_val),
      .left_data (l_data),
      .left_occ  (l_occ),
      .right_data(r_data),
      .right_occ (r_occ),
      .data      (cell_data[i]),
      .occ       (cell_occ[i]),
      .is_tail   (cell_tail[i])
    );
  end

  // tail pick: AND-OR over the one-hot tail marks
  always_comb begin
    tail_sel = '0;
    for (int k = 0; k < DEPTH; k++) begin
      tail_sel = tail_sel | (cell_data[k] & {DATA_WIDTH{cell_tail[k]}});
    end
  end

  // handshake control
  always_comb begin
    busy_nxt      = accept ? 1'b1 : (load ? 1'b0 : busy_r);
    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  // result register, read after the row has settled
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    if (load) begin
      out_data_r.status        <= status_r;
      out_data_r.element_count <= 5'(count_r);
      out_data_r.is_empty      <= is_emp;
      out_data_r.head_value    <= 32'(cell_data[0] & {DATA_WIDTH{cell_occ[0]}});
      out_data_r.tail_value    <= 32'(tail_sel);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // count tracks the occupancy marks in the row
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CW'($countones(cell_occ)))
    else $error("element count out of step with cell occupancy");

  // occupied cells form one run starting at the head
  a_occ_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_occ & (cell_occ + DEPTH'(1))) == '0)
    else $error("cell occupancy not contiguous from head");

  // at most one tail mark, and one exactly when not empty
  a_tail_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    is_emp ? (cell_tail == '0) : $onehot(cell_tail))
    else $error("tail mark not unique");

endmodule
